@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the execute unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ design/r8de_pkg.sv @@
// ----------------------------------------------------------------------------
// r8de_pkg
// opcodes, flag positions, defaults and the execute result type
// ----------------------------------------------------------------------------
package r8de_pkg;

	localparam int NUM_REGS_DEF   = 64;
	localparam int DATA_WORDS_DEF = 2048;

	localparam int WORD_W  = 16;
	localparam int FIELD_W = 6;
	localparam int BYTE_W  = 8;
	localparam int FLAG_W  = 5;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 40;

	// flag bit positions
	localparam int FLAG_C = 4;
	localparam int FLAG_V = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_S = 1;
	localparam int FLAG_Z = 0;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_LDI  = 4'd3,
		OP_BEQZ = 4'd4,
		OP_AND  = 4'd5,
		OP_OR   = 4'd6,
		OP_JR   = 4'd7,
		OP_SLC  = 4'd8,
		OP_SRC  = 4'd9,
		OP_LB   = 4'd10,
		OP_SB   = 4'd11
	} opcode_t;

	typedef struct packed {
		logic              wr;
		logic              mw;
		logic              rd;
		logic [BYTE_W-1:0] val;
		logic [WORD_W-1:0] npc;
		logic [FLAG_W-1:0] flags;
	} exec_res_t;

endpackage

@@ design/r8de_ram.sv @@
// ----------------------------------------------------------------------------
// r8de_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module r8de_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/r8de_alu.sv @@
// ----------------------------------------------------------------------------
// r8de_alu
// executes one decoded instruction on its operands and the current flags
// ----------------------------------------------------------------------------
module r8de_alu (
	input  r8de_pkg::opcode_t                  op,
	input  logic [r8de_pkg::FIELD_W-1:0]       rb_field,
	input  logic [r8de_pkg::BYTE_W-1:0]        a,
	input  logic [r8de_pkg::BYTE_W-1:0]        b,
	input  logic [r8de_pkg::BYTE_W-1:0]        ld_byte,
	input  logic [r8de_pkg::WORD_W-1:0]        pc,
	input  logic [r8de_pkg::FLAG_W-1:0]        flags_in,
	input  logic                               a_idx_ok,
	input  logic                               st_ok,
	output r8de_pkg::exec_res_t                result
);

	logic [8:0]  sum;
	logic [8:0]  diff;
	logic [15:0] prod;
	logic [15:0] rotl;
	logic [15:0] rotr;
	logic [15:0] sx;
	logic [2:0]  sh;
	logic [7:0]  val;
	logic [4:0]  f;
	logic        wr;
	logic        mw;
	logic        rd;
	logic [15:0] npc;
	logic        v;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};
	assign prod = {8'd0, a} * {8'd0, b};
	assign sh   = rb_field[2:0];
	assign rotl = {a, a} << sh;
	assign rotr = {a, a} >> sh;
	assign sx   = {{10{rb_field[5]}}, rb_field};

	always_comb begin
		val = '0;
		f   = flags_in;
		wr  = 1'b0;
		mw  = 1'b0;
		rd  = 1'b0;
		npc = '0;
		v   = 1'b0;
		case (op)
			r8de_pkg::OP_ADD: begin
				val = sum[7:0];
				v   = ~(a[7] ^ b[7]) & (val[7] ^ b[7]);
				f[r8de_pkg::FLAG_C] = sum[8];
				f[r8de_pkg::FLAG_V] = v;
				f[r8de_pkg::FLAG_S] = v ^ val[7];
				wr  = 1'b1;
			end
			r8de_pkg::OP_SUB: begin
				val = diff[7:0];
				v   = (a[7] ^ b[7]) & ~(val[7] ^ b[7]);
				f[r8de_pkg::FLAG_C] = diff[8];
				f[r8de_pkg::FLAG_V] = v;
				f[r8de_pkg::FLAG_S] = v ^ val[7];
				wr  = 1'b1;
			end
			r8de_pkg::OP_MUL: begin
				val = prod[7:0];
				wr  = 1'b1;
			end
			r8de_pkg::OP_LDI: begin
				val = sx[7:0];
				wr  = 1'b1;
			end
			r8de_pkg::OP_BEQZ: begin
				if (a == 8'd0) begin
					rd  = 1'b1;
					npc = pc + sx;
				end
			end
			r8de_pkg::OP_AND: begin
				val = a & b;
				wr  = 1'b1;
			end
			r8de_pkg::OP_OR: begin
				val = a | b;
				wr  = 1'b1;
			end
			r8de_pkg::OP_JR: begin
				rd  = 1'b1;
				npc = {a, b};
			end
			r8de_pkg::OP_SLC: begin
				val = rotl[15:8];
				wr  = 1'b1;
			end
			r8de_pkg::OP_SRC: begin
				val = rotr[7:0];
				wr  = 1'b1;
			end
			r8de_pkg::OP_LB: begin
				val = ld_byte;
				wr  = 1'b1;
			end
			r8de_pkg::OP_SB: begin
				mw = st_ok;
			end
			default: begin
			end
		endcase
		// n and z follow every arithmetic, logic and rotate result
		case (op)
			r8de_pkg::OP_ADD, r8de_pkg::OP_SUB, r8de_pkg::OP_MUL, r8de_pkg::OP_AND,
			r8de_pkg::OP_OR, r8de_pkg::OP_SLC, r8de_pkg::OP_SRC: begin
				f[r8de_pkg::FLAG_N] = val[7];
				f[r8de_pkg::FLAG_Z] = (val == 8'd0);
			end
			default: begin
			end
		endcase
		wr = wr & a_idx_ok;
		if (!wr) begin
			val = '0;
		end
	end

	assign result = '{wr: wr, mw: mw, rd: rd, val: val, npc: npc, flags: f};

endmodule

@@ design/risc8_decode_execute_unit.sv @@
// path: an accepted request is registered into the execute stage, then its result into the m_tdata register
// throughput: one instruction per cycle while m_tready does not stall; operands come
//   from the register file rams, read at accept, and are forwarded from the previous execute-stage write
// reset: clears the pipeline valids, flags, forwarding and per-entry valid bits;
//   ram contents are not swept, an entry never written reads as zero
// ----------------------------------------------------------------------------
// risc8_decode_execute_unit
// execute unit of an eight-bit harvard risc core with ram-held register file
// and data store, read-modify-write with one-deep forwarding
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module risc8_decode_execute_unit #(
	parameter int NUM_REGS   = r8de_pkg::NUM_REGS_DEF,
	parameter int DATA_WORDS = r8de_pkg::DATA_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// instr_word [15:0], instr_addr [31:16]
	input  logic [r8de_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// reg_write [0], reg_index [6:1], reg_value [14:7], mem_write [15],
	// redirect [16], next_pc [32:17], flags [37:33], zero fill [39:38]
	output logic [r8de_pkg::OUT_W-1:0]  m_tdata
);

	localparam int RW = $clog2(NUM_REGS);
	localparam int DW = $clog2(DATA_WORDS);
	localparam int DS_SLOTS = 1 << r8de_pkg::FIELD_W;  // addresses reachable by lb/sb

	// request decode at the input side
	logic                          accept;
	logic [r8de_pkg::WORD_W-1:0]   in_word;
	logic [r8de_pkg::WORD_W-1:0]   in_addr;
	logic [r8de_pkg::FIELD_W-1:0]  in_ra;
	logic [r8de_pkg::FIELD_W-1:0]  in_rb;
	logic                          in_ra_ok;
	logic                          in_rb_ok;
	logic                          in_d_ok;

	// execute stage
	logic                          valid_s1;
	logic [r8de_pkg::WORD_W-1:0]   word_s1;
	logic [r8de_pkg::WORD_W-1:0]   addr_s1;
	logic                          ra_ok_s1;
	logic                          rb_ok_s1;
	logic                          d_ok_s1;
	logic                          ra_vld_s1;
	logic                          rb_vld_s1;
	logic                          d_vld_s1;
	logic                          adv_s1;

	logic [r8de_pkg::FIELD_W-1:0]  ra_s1;
	logic [r8de_pkg::FIELD_W-1:0]  rb_s1;
	logic [r8de_pkg::BYTE_W-1:0]   ram_a;
	logic [r8de_pkg::BYTE_W-1:0]   ram_b;
	logic [r8de_pkg::BYTE_W-1:0]   ram_d;
	logic [r8de_pkg::BYTE_W-1:0]   op_a;
	logic [r8de_pkg::BYTE_W-1:0]   op_b;
	logic [r8de_pkg::BYTE_W-1:0]   op_d;
	r8de_pkg::exec_res_t           res;

	// architectural state outside the rams
	logic [r8de_pkg::FLAG_W-1:0]   flags_q;
	logic [NUM_REGS-1:0]           rf_vld_q;
	logic [DS_SLOTS-1:0]           ds_vld_q;

	// last register write and last store, for reads that raced them
	logic                          rf_fwd_vld_q;
	logic [RW-1:0]                 rf_fwd_idx_q;
	logic [r8de_pkg::BYTE_W-1:0]   rf_fwd_val_q;
	logic                          ds_fwd_vld_q;
	logic [r8de_pkg::FIELD_W-1:0]  ds_fwd_adr_q;
	logic [r8de_pkg::BYTE_W-1:0]   ds_fwd_val_q;

	logic                          rf_we;
	logic                          ds_we;

	// output register
	logic                          m_tvalid_q;
	logic [r8de_pkg::OUT_W-1:0]    m_tdata_q;

	// ------------------------------------------------------------------
	// input side: accept while the execute stage is empty or moving on
	// ------------------------------------------------------------------
	assign adv_s1   = valid_s1 & (~m_tvalid_q | m_tready);
	assign s_tready = ~valid_s1 | ~m_tvalid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	assign in_word  = s_tdata[15:0];
	assign in_addr  = s_tdata[31:16];
	assign in_ra    = in_word[11:6];
	assign in_rb    = in_word[5:0];
	assign in_ra_ok = (32'(in_ra) < NUM_REGS);
	assign in_rb_ok = (32'(in_rb) < NUM_REGS);
	assign in_d_ok  = (32'(in_rb) < DATA_WORDS);

	// register file: two copies so both operands are read in the same cycle
	r8de_ram #(.WIDTH(r8de_pkg::BYTE_W), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (ra_s1[RW-1:0]),
		.wdata (res.val),
		.re    (accept),
		.raddr (in_ra[RW-1:0]),
		.rdata (ram_a)
	);

	r8de_ram #(.WIDTH(r8de_pkg::BYTE_W), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (ra_s1[RW-1:0]),
		.wdata (res.val),
		.re    (accept),
		.raddr (in_rb[RW-1:0]),
		.rdata (ram_b)
	);

	// data store, indexed by the 6-bit unsigned immediate
	r8de_ram #(.WIDTH(r8de_pkg::BYTE_W), .DEPTH(DATA_WORDS)) u_dstore (
		.clk   (clk),
		.we    (ds_we),
		.waddr (DW'(rb_s1)),
		.wdata (op_a),
		.re    (accept),
		.raddr (DW'(in_rb)),
		.rdata (ram_d)
	);

	// ------------------------------------------------------------------
	// execute stage operands: forwarding beats ram, never-written reads 0
	// ------------------------------------------------------------------
	assign ra_s1 = word_s1[11:6];
	assign rb_s1 = word_s1[5:0];

	always_comb begin
		op_a = '0;
		op_b = '0;
		op_d = '0;
		if (ra_ok_s1) begin
			if (rf_fwd_vld_q && rf_fwd_idx_q == ra_s1[RW-1:0]) begin
				op_a = rf_fwd_val_q;
			end else if (ra_vld_s1) begin
				op_a = ram_a;
			end
		end
		if (rb_ok_s1) begin
			if (rf_fwd_vld_q && rf_fwd_idx_q == rb_s1[RW-1:0]) begin
				op_b = rf_fwd_val_q;
			end else if (rb_vld_s1) begin
				op_b = ram_b;
			end
		end
		if (d_ok_s1) begin
			if (ds_fwd_vld_q && ds_fwd_adr_q == rb_s1) begin
				op_d = ds_fwd_val_q;
			end else if (d_vld_s1) begin
				op_d = ram_d;
			end
		end
	end

	r8de_alu u_alu (
		.op       (r8de_pkg::opcode_t'(word_s1[15:12])),
		.rb_field (rb_s1),
		.a        (op_a),
		.b        (op_b),
		.ld_byte  (op_d),
		.pc       (addr_s1),
		.flags_in (flags_q),
		.a_idx_ok (ra_ok_s1),
		.st_ok    (d_ok_s1),
		.result   (res)
	);

	assign rf_we = adv_s1 & res.wr;
	assign ds_we = adv_s1 & res.mw;

	// ------------------------------------------------------------------
	// stage registers, state update and output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			flags_q      <= '0;
			rf_vld_q     <= '0;
			ds_vld_q     <= '0;
			rf_fwd_vld_q <= 1'b0;
			ds_fwd_vld_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				flags_q    <= res.flags;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (rf_we) begin
				rf_vld_q[ra_s1[RW-1:0]] <= 1'b1;
				rf_fwd_vld_q            <= 1'b1;
			end
			if (ds_we) begin
				ds_vld_q[rb_s1] <= 1'b1;
				ds_fwd_vld_q    <= 1'b1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1   <= in_word;
			addr_s1   <= in_addr;
			ra_ok_s1  <= in_ra_ok;
			rb_ok_s1  <= in_rb_ok;
			d_ok_s1   <= in_d_ok;
			ra_vld_s1 <= in_ra_ok ? rf_vld_q[in_ra[RW-1:0]] : 1'b0;
			rb_vld_s1 <= in_rb_ok ? rf_vld_q[in_rb[RW-1:0]] : 1'b0;
			d_vld_s1  <= ds_vld_q[in_rb];
		end
		if (rf_we) begin
			rf_fwd_idx_q <= ra_s1[RW-1:0];
			rf_fwd_val_q <= res.val;
		end
		if (ds_we) begin
			ds_fwd_adr_q <= rb_s1;
			ds_fwd_val_q <= op_a;
		end
		if (adv_s1) begin
			m_tdata_q <= {2'b00, res.flags, res.npc, res.rd, res.mw, res.val,
				(res.wr ? ra_s1 : 6'd0), res.wr};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// no request is taken while the execute stage is stuck
	`ASSERT_IMPL(a_no_overrun, clk, arst_n, accept, (!valid_s1 || adv_s1))
	// a stalled instruction stays in the execute stage
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, (valid_s1 && !adv_s1), valid_s1)
	// the forwarding register tracks the register file write just made
	`ASSERT_NEXT(a_fwd_track, clk, arst_n, rf_we,
		(rf_fwd_vld_q && rf_fwd_idx_q == $past(ra_s1[RW-1:0])))
	// every executed instruction lands in the output register
	`ASSERT_NEXT(a_out_load, clk, arst_n, adv_s1, m_tvalid_q)

endmodule

@@ test/risc8_decode_execute_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc8_decode_execute_unit_tb
// drives instruction requests into the execute unit and checks every retired
// result field by field against a cycle-free model of the register file, data
// store and status flags, under several patterns of source gaps and sink stalls
// ----------------------------------------------------------------------------
module risc8_decode_execute_unit_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int REPORT_MAX  = 10;
	localparam int DRAIN_WAIT  = 10;
	localparam int RAND_PER_PHASE = 330;
	localparam int HOLD_CYCLES = 400;

	// opcodes 12 to 15 have no meaning and must leave all state alone
	localparam logic [3:0] OP_UNUSED_LO = 4'd12;

	// retired result as it sits on m_tdata, lowest field last
	typedef struct packed {
		logic [1:0]  fill;
		logic [4:0]  flags;
		logic [15:0] next_pc;
		logic        redirect;
		logic        mem_write;
		logic [7:0]  reg_value;
		logic [5:0]  reg_index;
		logic        reg_write;
	} retire_t;

	// shadow of the architectural state plus the queue of retirements still owed
	class retire_checker;
		logic [7:0] regfile [r8de_pkg::NUM_REGS_DEF];
		logic [7:0] dmem [r8de_pkg::DATA_WORDS_DEF];
		logic [4:0] status;
		retire_t    pending_results[$];
		int         n_errors;
		int         n_instr;
		int         n_results;
		int         n_redirects;
		int         n_stores;

		function new();
			foreach (regfile[i]) regfile[i] = 8'h00;
			foreach (dmem[i]) dmem[i] = 8'h00;
			status = '0;
			n_errors = 0;
			n_instr = 0;
			n_results = 0;
			n_redirects = 0;
			n_stores = 0;
		endfunction

		function void report(string what, logic [39:0] want_v, logic [39:0] got_v);
			n_errors++;
			if (n_errors <= REPORT_MAX)
				$display("mismatch on result %0d: %s expected %0h got %0h",
					n_results, what, want_v, got_v);
		endfunction

		// executes one accepted instruction and queues the result it must retire
		function void retire_instr(logic [15:0] word, logic [15:0] pc);
			logic [5:0] ra;
			logic [5:0] rb;
			logic [7:0] a;
			logic [7:0] b;
			logic [7:0] v;
			logic [15:0] ext;
			logic [8:0] sum;
			logic [2:0] amt;
			logic [4:0] f;
			logic wr;
			logic upd_nz;
			logic upd_s;
			retire_t r;
			ra = word[11:6];
			rb = word[5:0];
			a = (ra < r8de_pkg::NUM_REGS_DEF) ? regfile[ra] : 8'h00;
			b = (rb < r8de_pkg::NUM_REGS_DEF) ? regfile[rb] : 8'h00;
			ext = {{10{rb[5]}}, rb};
			amt = rb[2:0];
			f = status;
			v = 8'h00;
			wr = 1'b0;
			upd_nz = 1'b0;
			upd_s = 1'b0;
			r = '0;
			case (word[15:12])
				r8de_pkg::OP_ADD: begin
					sum = {1'b0, a} + {1'b0, b};
					v = sum[7:0];
					f[r8de_pkg::FLAG_C] = sum[8];
					f[r8de_pkg::FLAG_V] = (a[7] == b[7]) && (v[7] != b[7]);
					{wr, upd_nz, upd_s} = 3'b111;
				end
				r8de_pkg::OP_SUB: begin
					// bit 8 of the nine-bit difference is the borrow
					sum = {1'b0, a} - {1'b0, b};
					v = sum[7:0];
					f[r8de_pkg::FLAG_C] = sum[8];
					f[r8de_pkg::FLAG_V] = (a[7] != b[7]) && (v[7] == b[7]);
					{wr, upd_nz, upd_s} = 3'b111;
				end
				r8de_pkg::OP_MUL: begin
					v = a * b;
					{wr, upd_nz} = 2'b11;
				end
				r8de_pkg::OP_LDI: begin
					v = ext[7:0];
					wr = 1'b1;
				end
				r8de_pkg::OP_BEQZ: begin
					if (a == 8'h00) begin
						r.redirect = 1'b1;
						r.next_pc = pc + ext;
					end
				end
				r8de_pkg::OP_AND: begin
					v = a & b;
					{wr, upd_nz} = 2'b11;
				end
				r8de_pkg::OP_OR: begin
					v = a | b;
					{wr, upd_nz} = 2'b11;
				end
				r8de_pkg::OP_JR: begin
					r.redirect = 1'b1;
					r.next_pc = {a, b};
				end
				r8de_pkg::OP_SLC: begin
					v = (amt == 3'd0) ? a : ((a << amt) | (a >> (4'd8 - amt)));
					{wr, upd_nz} = 2'b11;
				end
				r8de_pkg::OP_SRC: begin
					v = (amt == 3'd0) ? a : ((a >> amt) | (a << (4'd8 - amt)));
					{wr, upd_nz} = 2'b11;
				end
				r8de_pkg::OP_LB: begin
					v = (rb < r8de_pkg::DATA_WORDS_DEF) ? dmem[rb] : 8'h00;
					wr = 1'b1;
				end
				r8de_pkg::OP_SB: begin
					if (rb < r8de_pkg::DATA_WORDS_DEF) begin
						dmem[rb] = a;
						r.mem_write = 1'b1;
					end
				end
				default: ;
			endcase
			if (upd_nz) begin
				f[r8de_pkg::FLAG_N] = v[7];
				f[r8de_pkg::FLAG_Z] = (v == 8'h00);
			end
			if (upd_s)
				f[r8de_pkg::FLAG_S] = f[r8de_pkg::FLAG_V] ^ f[r8de_pkg::FLAG_N];
			if (wr && ra < r8de_pkg::NUM_REGS_DEF) begin
				regfile[ra] = v;
				r.reg_write = 1'b1;
				r.reg_index = ra;
				r.reg_value = v;
			end
			status = f;
			r.flags = f;
			if (r.redirect) n_redirects++;
			if (r.mem_write) n_stores++;
			n_instr++;
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [39:0] data);
			retire_t got;
			retire_t want;
			got = data;
			n_results++;
			if (pending_results.size() == 0) begin
				report("result with nothing pending", '0, data);
			end else begin
				want = pending_results.pop_front();
				if (got.fill !== want.fill) report("zero fill", want.fill, got.fill);
				if (got.reg_write !== want.reg_write)
					report("reg_write", want.reg_write, got.reg_write);
				if (got.reg_index !== want.reg_index)
					report("reg_index", want.reg_index, got.reg_index);
				if (got.reg_value !== want.reg_value)
					report("reg_value", want.reg_value, got.reg_value);
				if (got.mem_write !== want.mem_write)
					report("mem_write", want.mem_write, got.mem_write);
				if (got.redirect !== want.redirect)
					report("redirect", want.redirect, got.redirect);
				if (got.next_pc !== want.next_pc) report("next_pc", want.next_pc, got.next_pc);
				if (got.flags !== want.flags) report("flags", want.flags, got.flags);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// instr_word [15:0], instr_addr [31:16]
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// reg_write [0], reg_index [6:1], reg_value [14:7], mem_write [15],
	// redirect [16], next_pc [32:17], flags [37:33], zero fill [39:38]
	logic [39:0] m_tdata;

	retire_checker chk;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        hold_output;
	logic [15:0] fetch_pc;
	int          idle_cycles;
	int          idle_tab [5] = '{0, 62, 0, 36, 0};
	int          stall_tab [5] = '{0, 0, 62, 36, 0};

	risc8_decode_execute_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sink side: random stalls, or a long hold-off while the pressure phase runs
	always @(negedge clk) begin
		m_tready <= !hold_output && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// both handshakes are observed here; results are checked before the
	// request of the same edge is noted, which cannot be its own result anyway
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			chk.check_result(m_tdata);
		if (arst_n && s_tvalid && s_tready)
			chk.retire_instr(s_tdata[15:0], s_tdata[31:16]);
	end

	// watchdog: any stretch with no handshake on either side counts toward the limit
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a handshake", idle_cycles);
			$display("risc8_decode_execute_unit_tb NOT OK");
			$finish;
		end
	end

	function automatic logic [15:0] instr(logic [3:0] op, int ra, int rb);
		return {op, 6'(ra), 6'(rb)};
	endfunction

	// offers one request, with random gaps before it, and returns once accepted
	task automatic send_instr(input logic [15:0] word, input logic [15:0] pc);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pc, word};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// mostly a small pool of registers so results feed straight into the next
	// instruction; a few unused opcodes as noise
	task automatic send_random(input int count);
		logic [3:0] op;
		int ra;
		int rb;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 8)
				op = OP_UNUSED_LO + 4'($urandom_range(0, 3));
			else
				op = 4'($urandom_range(0, 11));
			ra = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
			rb = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 63);
			if ($urandom_range(0, 99) < 5)
				fetch_pc = 16'($urandom);
			else
				fetch_pc = fetch_pc + 16'd1;
			send_instr(instr(op, ra, rb), fetch_pc);
		end
	endtask

	task automatic hold_results(input int cycles);
		@(posedge clk);
		hold_output <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_output <= 1'b0;
	endtask

	initial begin
		chk = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		hold_output = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fetch_pc = 16'h0100;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: immediate extremes, carry and borrow, zero results
		send_instr(instr(r8de_pkg::OP_LDI, 1, 6'h20), 16'h0000);
		send_instr(instr(r8de_pkg::OP_LDI, 2, 6'h1f), 16'h0001);
		send_instr(instr(r8de_pkg::OP_LDI, 63, 6'h3f), 16'hffff);
		send_instr(instr(r8de_pkg::OP_ADD, 1, 1), 16'h0002);
		send_instr(instr(r8de_pkg::OP_ADD, 2, 63), 16'h0003);
		send_instr(instr(r8de_pkg::OP_SUB, 4, 63), 16'h0004);
		send_instr(instr(r8de_pkg::OP_SUB, 2, 2), 16'h0005);
		send_instr(instr(r8de_pkg::OP_MUL, 63, 63), 16'h0006);
		send_instr(instr(r8de_pkg::OP_AND, 1, 63), 16'h0007);
		send_instr(instr(r8de_pkg::OP_OR, 5, 0), 16'h0008);
		// rotate amount is the immediate mod 8, zero included
		send_instr(instr(r8de_pkg::OP_SLC, 1, 0), 16'h0009);
		send_instr(instr(r8de_pkg::OP_SLC, 1, 11), 16'h000a);
		send_instr(instr(r8de_pkg::OP_SRC, 1, 63), 16'h000b);
		send_instr(instr(r8de_pkg::OP_SRC, 63, 8), 16'h000c);
		// branch targets wrapping both ways, then a branch not taken
		send_instr(instr(r8de_pkg::OP_BEQZ, 2, 6'h20), 16'h0010);
		send_instr(instr(r8de_pkg::OP_BEQZ, 0, 6'h1f), 16'hfff0);
		send_instr(instr(r8de_pkg::OP_BEQZ, 63, 5), 16'h0020);
		send_instr(instr(r8de_pkg::OP_JR, 63, 1), 16'h0021);
		// store at both ends of the immediate range, load back and load unwritten
		send_instr(instr(r8de_pkg::OP_SB, 63, 63), 16'h0022);
		send_instr(instr(r8de_pkg::OP_SB, 1, 0), 16'h0023);
		send_instr(instr(r8de_pkg::OP_LB, 6, 63), 16'h0024);
		send_instr(instr(r8de_pkg::OP_LB, 7, 30), 16'h0025);
		for (int k = 0; k < 4; k++)
			send_instr(instr(OP_UNUSED_LO + 4'(k), $urandom_range(0, 63),
				$urandom_range(0, 63)), 16'($urandom));

		// random phases: free running, source gaps, sink stalls, both, sink hold-off
		for (int ph = 0; ph < 5; ph++) begin
			send_idle_pct = idle_tab[ph];
			recv_stall_pct = stall_tab[ph];
			if (ph == 4) begin
				fork
					hold_results(HOLD_CYCLES);
					send_random(RAND_PER_PHASE);
				join
			end else begin
				send_random(RAND_PER_PHASE);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (chk.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("executed %0d instructions, directed then random under five gap and stall patterns",
			chk.n_instr);
		$display("checked %0d results, %0d redirects and %0d stores among them, %0d mismatches",
			chk.n_results, chk.n_redirects, chk.n_stores, chk.n_errors);
		if (chk.n_errors == 0)
			$display("risc8_decode_execute_unit_tb OK");
		else
			$display("risc8_decode_execute_unit_tb NOT OK");
		$finish;
	end

endmodule
